/* rtl/glo_pkg.sv */
// Shared types and constants for the grid line overlap counter.
package glo_pkg;

    localparam int GRID_SIDE_DEF = 1024;
    localparam int COORD_W       = 10;
    localparam int TOTAL_W       = 21;
    localparam int MARKED_W      = 11;
    localparam int CNT_W         = 2;

    localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_SAT   = CNT_W'(2);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_req;

    typedef struct packed {
        logic [TOTAL_W-1:0]  overlap_total;
        logic [MARKED_W-1:0] cells_marked;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

/* rtl/grid_line_overlap_counter.sv */
// Each request walks N = max(|dx|,|dy|) + 1 path cells before its result is registered.
// A new request is taken only after the last one drains; the path walk does one RAM read-modify-write
//   per cell through a 3-stage address/read/write pipeline on a single counter RAM.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all
//   GRID_SIDE*GRID_SIDE counters, one per cycle, with the input stalled meanwhile.
// The output register lets a new request be accepted while a result waits.
module grid_line_overlap_counter #(
    parameter int GRID_SIDE = glo_pkg::GRID_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  glo_pkg::t_req i_in_req,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output glo_pkg::t_rsp o_out_rsp,
    input  logic          i_out_stall
);

    import glo_pkg::*;

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(GRID_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(DEPTH - 1);

    // sequencer
    t_state r_state, n_state;

    // walker position and target
    logic [COORD_W-1:0]  r_x, r_y, r_ex, r_ey;
    logic [COORD_W-1:0]  n_x, n_y;
    logic [MARKED_W-1:0] r_marked;

    // clearing pass
    logic [ADDR_W-1:0] r_clr_addr;

    // pipeline: stage 1 holds the RAM read address, stage 2 lines up with read data
    logic              r_s1_vld, r_s1_in;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_vld, r_s2_in;
    logic [ADDR_W-1:0] r_s2_addr;

    logic [TOTAL_W-1:0] r_total;

    logic r_out_vld;
    t_rsp r_out;

    // control decode
    logic w_accept, w_issue, w_last, w_load, w_clear_done;
    logic w_pipe_empty;
    logic w_in_grid;
    logic [ADDR_W-1:0] w_addr;

    // RAM side
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CNT_W-1:0]  w_wdata;
    logic [CNT_W-1:0]  w_rdata;
    logic              w_bump;

    glo_ram #(
        .WIDTH(CNT_W),
        .DEPTH(DEPTH)
    ) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_s1_addr),
        .o_rdata(w_rdata)
    );

    // king-move step toward the end point, one axis unit each
    always_comb begin
        if (r_x > r_ex) begin
            n_x = r_x - COORD_W'(1);
        end else if (r_x < r_ex) begin
            n_x = r_x + COORD_W'(1);
        end else begin
            n_x = r_x;
        end
        if (r_y > r_ey) begin
            n_y = r_y - COORD_W'(1);
        end else if (r_y < r_ey) begin
            n_y = r_y + COORD_W'(1);
        end else begin
            n_y = r_y;
        end
    end

    // cells off the grid are walked but never touch the RAM;
    // the truncated product is only used for cells inside the grid
    assign w_in_grid = (CMP_W'(r_x) < CMP_W'(GRID_SIDE)) && (CMP_W'(r_y) < CMP_W'(GRID_SIDE));
    assign w_addr    = ADDR_W'(r_x) * ADDR_W'(GRID_SIDE) + ADDR_W'(r_y);

    assign w_last       = (r_x == r_ex) && (r_y == r_ey);
    assign w_pipe_empty = !r_s1_vld && !r_s2_vld;
    assign w_clear_done = (r_clr_addr == LAST_CELL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_pipe_empty && (!r_out_vld || !i_out_stall)) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_issue    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            ST_WALK: begin
                w_issue = 1'b1;
            end
            ST_DRAIN: begin
                w_load = w_pipe_empty && (!r_out_vld || !i_out_stall);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // read-modify-write at stage 2; path cells never repeat, so no forwarding
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_s2_addr;
        w_wdata = w_rdata + CNT_W'(1);
        w_bump  = 1'b0;
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (r_s2_vld && r_s2_in && (w_rdata < CNT_SAT)) begin
            w_we   = 1'b1;
            w_bump = (w_rdata == CNT_ONE) && (r_total != TOTAL_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_total    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (w_bump) begin
                r_total <= r_total + TOTAL_W'(1);
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x      <= i_in_req.start_x;
            r_y      <= i_in_req.start_y;
            r_ex     <= i_in_req.end_x;
            r_ey     <= i_in_req.end_y;
            r_marked <= '0;
        end else if (w_issue) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_marked <= r_marked + MARKED_W'(1);
        end
        r_s1_addr <= w_addr;
        r_s1_in   <= w_in_grid;
        r_s2_addr <= r_s1_addr;
        r_s2_in   <= r_s1_in;
        if (w_load) begin
            r_out.overlap_total <= r_total;
            r_out.cells_marked  <= r_marked;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

endmodule

/* rtl/glo_ram.sv */
// Generic simple dual-port RAM with registered read.
module glo_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/grid_line_overlap_checker.sv */
// Checker for the grid line overlap counter: predicts results and compares them.
`timescale 1ns / 100ps

module grid_line_overlap_checker #(
    parameter int GRID_SIDE = glo_pkg::GRID_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  glo_pkg::t_req i_in_req,
    input  logic          i_in_stall,
    input  logic          i_out_valid,
    input  glo_pkg::t_rsp i_out_rsp,
    input  logic          i_out_stall,
    output int            o_pending,
    output int            o_fail_count
);
    import glo_pkg::*;

    // Shadow of the counter RAM, one saturating 2-bit count per cell.
    bit [CNT_W-1:0]     cover_grid [GRID_SIDE*GRID_SIDE];
    logic [TOTAL_W-1:0] overlap_cells = '0;
    t_rsp               expected_rsp [$];
    int                 fail_count = 0;

    function automatic void cover_cell(int unsigned x, int unsigned y);
        int unsigned idx;
        // cells past the grid edge are walked but never stored
        if (x >= GRID_SIDE || y >= GRID_SIDE) return;
        idx = x * GRID_SIDE + y;
        if (cover_grid[idx] != CNT_SAT) begin
            cover_grid[idx] = cover_grid[idx] + 1'b1;
            if (cover_grid[idx] == CNT_SAT && overlap_cells != TOTAL_MAX)
                overlap_cells = overlap_cells + 1'b1;
        end
    endfunction

    // King-move walk: each axis not yet at the end point steps toward it on every iteration.
    function automatic t_rsp trace_segment(t_req seg);
        int unsigned x, y, ex, ey, steps;
        t_rsp        rsp;
        x     = 32'(seg.start_x);
        y     = 32'(seg.start_y);
        ex    = 32'(seg.end_x);
        ey    = 32'(seg.end_y);
        steps = 1;
        cover_cell(x, y);
        while (x != ex || y != ey) begin
            if (x < ex) x++;
            else if (x > ex) x--;
            if (y < ey) y++;
            else if (y > ey) y--;
            cover_cell(x, y);
            steps++;
        end
        rsp.overlap_total = overlap_cells;
        rsp.cells_marked  = MARKED_W'(steps);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (cover_grid[i]) cover_grid[i] = '0;
            overlap_cells = '0;
            expected_rsp.delete();
        end else begin
            // results first: a request taken at this edge cannot answer at it
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: result with none expected, actual total %0d cells %0d",
                             $time, i_out_rsp.overlap_total, i_out_rsp.cells_marked);
                    fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_out_rsp.overlap_total !== want.overlap_total) begin
                        $display("%0t: overlap_total expected %0d actual %0d",
                                 $time, want.overlap_total, i_out_rsp.overlap_total);
                        fail_count++;
                    end
                    if (i_out_rsp.cells_marked !== want.cells_marked) begin
                        $display("%0t: cells_marked expected %0d actual %0d",
                                 $time, want.cells_marked, i_out_rsp.cells_marked);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_rsp.insert(expected_rsp.size(), trace_segment(i_in_req));
        end
        o_pending    <= expected_rsp.size();
        o_fail_count <= fail_count;
    end

endmodule

/* verif/grid_line_overlap_counter_tb.sv */
// Testbench top for the grid line overlap counter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module grid_line_overlap_counter_tb;
    import glo_pkg::*;

    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int RANDOM_ITEMS = 570;
    // long receiver hold-off; short segments fill the block well before it ends
    localparam int HOLD_CYCLES  = 400;
    // longest path is 1024 cells plus the pipeline
    localparam int DRAIN_CYCLES = 1100;

    typedef enum int {
        SHAPE_ROW,
        SHAPE_COLUMN,
        SHAPE_DIAGONAL,
        SHAPE_GENERAL
    } seg_shape_e;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic in_stall;
    logic out_valid;
    t_rsp out_rsp;
    logic out_stall = 1'b0;

    // shared between the request and result sides
    logic idle_on      = 1'b1;
    logic hold_off_req = 1'b0;

    int pending;
    int fail_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grid_line_overlap_counter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_rsp   (out_rsp),
        .i_out_stall (out_stall)
    );

    grid_line_overlap_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_req     (in_req),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_rsp    (out_rsp),
        .i_out_stall  (out_stall),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic t_req line_from(int sx, int sy, int ex, int ey);
        t_req s;
        s.start_x = COORD_W'(sx);
        s.start_y = COORD_W'(sy);
        s.end_x   = COORD_W'(ex);
        s.end_y   = COORD_W'(ey);
        return s;
    endfunction

    // Move d cells up or down at random, turning back at the grid edge.
    function automatic logic [COORD_W-1:0] step_from(int unsigned v, int unsigned d);
        bit down;
        down = 1'($urandom_range(1));
        if (down && v < d) down = 1'b0;
        if (!down && v + d > COORD_MAX) down = 1'b1;
        return down ? COORD_W'(v - d) : COORD_W'(v + d);
    endfunction

    // Random segment. Most land in one hot window so paths keep crossing;
    // a few span the whole grid, since each path cell costs a cycle.
    function automatic t_req pick_segment(int unsigned hot_x, int unsigned hot_y);
        t_req        s;
        int unsigned roll, span, base_x, base_y, reach;
        seg_shape_e  shape;
        roll = $urandom_range(99);
        if (roll < 2) begin
            s.start_x = COORD_W'($urandom);
            s.start_y = COORD_W'($urandom);
            s.end_x   = COORD_W'($urandom);
            s.end_y   = COORD_W'($urandom);
            return s;
        end
        span = (roll < 15) ? 63 : 15;
        if (roll < 75) begin
            base_x = hot_x;
            base_y = hot_y;
        end else begin
            base_x = $urandom_range(COORD_MAX - span);
            base_y = $urandom_range(COORD_MAX - span);
        end
        s.start_x = COORD_W'(base_x + $urandom_range(span));
        s.start_y = COORD_W'(base_y + $urandom_range(span));
        reach     = $urandom_range(span);
        shape     = seg_shape_e'($urandom_range(SHAPE_GENERAL));
        case (shape)
            SHAPE_ROW: begin
                s.end_x = step_from(32'(s.start_x), reach);
                s.end_y = s.start_y;
            end
            SHAPE_COLUMN: begin
                s.end_x = s.start_x;
                s.end_y = step_from(32'(s.start_y), reach);
            end
            SHAPE_DIAGONAL: begin
                s.end_x = step_from(32'(s.start_x), reach);
                s.end_y = step_from(32'(s.start_y), reach);
            end
            default: begin
                s.end_x = COORD_W'(base_x + $urandom_range(span));
                s.end_y = COORD_W'(base_y + $urandom_range(span));
            end
        endcase
        return s;
    endfunction

    // Offer one request and hold it until the block takes it. Valid may drop
    // for a few random cycles first; it is never lowered and raised in one step.
    task automatic send_segment(input t_req seg);
        if (idle_on && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 27);
        end
        in_valid <= 1'b1;
        in_req   <= seg;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off counted here so the
    // block backs up and stalls its input while requests keep coming.
    initial begin
        int held;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
            end
            out_stall <= idle_on && ($urandom_range(99) < 27);
        end
    end

    initial begin
        int unsigned hot_x, hot_y;
        hot_x = $urandom_range(COORD_MAX - 63);
        hot_y = $urandom_range(COORD_MAX - 63);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its whole RAM after reset with the input stalled;
        // the first request simply waits that out.

        // point segments at both corners; the repeats hit a cell to saturation
        send_segment(line_from(0, 0, 0, 0));
        send_segment(line_from(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(line_from(0, 0, 0, 0));
        send_segment(line_from(0, 0, 0, 0));
        // full-length row, a crossing column, then the row walked backward
        send_segment(line_from(0, 5, COORD_MAX, 5));
        send_segment(line_from(5, 0, 5, COORD_MAX));
        send_segment(line_from(COORD_MAX, 5, 0, 5));
        // both full diagonals
        send_segment(line_from(0, 0, COORD_MAX, COORD_MAX));
        send_segment(line_from(COORD_MAX, 0, 0, COORD_MAX));
        // off-45 slopes: diagonal run first, then straight
        send_segment(line_from(10, 20, 30, 25));
        send_segment(line_from(30, 25, 10, 20));
        send_segment(line_from(40, 40, 42, 60));
        send_segment(line_from(700, 300, 600, 310));
        // alternating bit patterns in every field
        send_segment(line_from('h2AA, 'h155, 'h155, 'h2AA));
        send_segment(line_from(COORD_MAX, 512, 1000, COORD_MAX));
        send_segment(line_from(3, COORD_MAX, 3, COORD_MAX - 3));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40) hold_off_req = 1'b1;
            // one long stretch where neither side idles
            idle_on = !(n >= 200 && n < 330);
            send_segment(pick_segment(hot_x, hot_y));
        end
        in_valid <= 1'b0;
        idle_on = 1'b1;

        // let the checker see the last request before asking what is left
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Timeout guard: the clearing pass and the whole run end before it,
    // even with every path at full length and the stalls.
    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
